@@ hw/rtl/isd_pkg.sv @@
// shared types, constants and register codes for the interrupt storm detector
// no dependencies; imported by isd_alu, isd_core and the top level
package isd_pkg;

    // vector space and the first vector that maps onto a maskable irq line
    localparam int NUM_VECTORS    = 64;
    localparam int FIRST_MASKABLE = 32;
    localparam int IDX_W          = $clog2(NUM_VECTORS);

    // fixed field widths
    localparam int VEC_W  = 6;
    localparam int CNT_W  = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // configuration port
    localparam int APB_AW = 3;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESH = 1'b1;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd100;
    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd2000;

    typedef struct packed {
        logic [CFG_W-1:0] window_ms;
        logic [CFG_W-1:0] storm_threshold;
    } t_cfg;

    typedef struct packed {
        logic [VEC_W-1:0] storm_vector;
        logic             maskable;
        logic [VEC_W-1:0] irq_line;
        logic [CNT_W-1:0] window_count;
        logic             last;
    } t_report;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              lt;
        logic              eq;
    } t_alu_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUMP,
        ST_WIN1,
        ST_WIN2,
        ST_SW_RD,
        ST_SW_CMP,
        ST_END
    } t_state;

endpackage

@@ hw/rtl/isd_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module isd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/isd_alu.sv @@
// shared 32 bit subtract and compare unit used by the count update, window and threshold steps of the sequencer
// depends on isd_pkg
module isd_alu (
    input  isd_pkg::t_alu_req i_req,
    output isd_pkg::t_alu_res o_res
);
    import isd_pkg::*;

    logic [TIME_W:0] diff_ext;

    // a - b with borrow out; borrow means a < b unsigned
    assign diff_ext   = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.diff = diff_ext[TIME_W-1:0];
    assign o_res.lt   = diff_ext[TIME_W];
    assign o_res.eq   = (diff_ext[TIME_W-1:0] == '0);

endmodule

@@ hw/rtl/isd_core.sv @@
// sequencer, count store, storm flags and report registers of the detector
// depends on isd_pkg, isd_ram and isd_alu
module isd_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  isd_pkg::t_cfg            i_cfg,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [isd_pkg::VEC_W-1:0]  i_vector,
    input  logic [isd_pkg::TIME_W-1:0] i_now_ms,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output isd_pkg::t_report         o_report
);
    import isd_pkg::*;

    t_state r_state, n_state;

    logic [IDX_W-1:0]       r_vec;
    logic                   r_in_range;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_start;
    logic [TIME_W-1:0]      r_diff;
    logic [IDX_W-1:0]       r_idx;
    logic [NUM_VECTORS-1:0] r_valid;
    logic [NUM_VECTORS-1:0] r_flags;
    t_report                r_out;
    logic                   r_out_valid;
    t_report                r_pend;
    logic                   r_pend_valid;

    logic             accept;
    logic             slot_free;
    logic             idx_last;
    logic             hit;
    logic             stall;
    logic [CNT_W-1:0] count;
    logic             count_valid;
    logic [CNT_W-1:0] rdata;
    t_report          new_rep;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [CNT_W-1:0] ram_wdata;
    t_alu_req         alu_req;
    t_alu_res         alu_res;

    // count store
    isd_ram #(
        .WIDTH(CNT_W),
        .DEPTH(NUM_VECTORS)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_vec),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    isd_alu u_alu (
        .i_req(alu_req),
        .o_res(alu_res)
    );

    // handshake and sweep helpers
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign idx_last    = (r_idx == IDX_W'(NUM_VECTORS - 1));
    assign count_valid = (r_state == ST_BUMP) ? r_valid[r_vec] : r_valid[r_idx];
    assign count       = count_valid ? rdata : '0;
    assign hit         = !alu_res.lt && !r_flags[r_idx];
    assign stall       = hit && r_pend_valid && !slot_free;

    // report built from the vector under the sweep
    always_comb begin
        new_rep              = '0;
        new_rep.storm_vector = VEC_W'(r_idx);
        new_rep.maskable     = (32'(r_idx) >= FIRST_MASKABLE);
        new_rep.irq_line     = new_rep.maskable ?
                               VEC_W'(r_idx - IDX_W'(FIRST_MASKABLE)) : '0;
        new_rep.window_count = count;
        new_rep.last         = 1'b0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_BUMP;
            end
            ST_BUMP: begin
                n_state = ST_WIN1;
            end
            ST_WIN1: begin
                if (alu_res.eq || (r_start == '0)) n_state = ST_IDLE;
                else n_state = ST_WIN2;
            end
            ST_WIN2: begin
                if (alu_res.lt) n_state = ST_IDLE;
                else n_state = ST_SW_RD;
            end
            ST_SW_RD: begin
                n_state = ST_SW_CMP;
            end
            ST_SW_CMP: begin
                if (!stall) n_state = idx_last ? ST_END : ST_SW_RD;
            end
            ST_END: begin
                if (!r_pend_valid || slot_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs and shared unit operands
    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_idx;
        ram_we     = 1'b0;
        ram_wdata  = '0;
        alu_req    = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = IDX_W'(i_vector);
            end
            ST_BUMP: begin
                // count + 1 as count - all-ones, held at the top
                alu_req.a = TIME_W'(count);
                alu_req.b = '1;
                ram_we    = r_in_range;
                ram_wdata = (count == COUNT_MAX) ? count : alu_res.diff[CNT_W-1:0];
            end
            ST_WIN1: begin
                alu_req.a = r_now;
                alu_req.b = r_start;
            end
            ST_WIN2: begin
                alu_req.a = r_diff;
                alu_req.b = TIME_W'(i_cfg.window_ms);
            end
            ST_SW_RD: begin
                ram_re = 1'b1;
            end
            ST_SW_CMP: begin
                alu_req.a = TIME_W'(count);
                alu_req.b = TIME_W'(i_cfg.storm_threshold);
            end
            ST_END: begin
                alu_req = '0;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // state, window and flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_flags      <= '0;
            r_start      <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_vec      <= IDX_W'(i_vector);
                        r_in_range <= (32'(i_vector) < NUM_VECTORS);
                        r_now      <= i_now_ms;
                    end
                end
                ST_BUMP: begin
                    if (r_in_range) r_valid[r_vec] <= 1'b1;
                end
                ST_WIN1: begin
                    r_diff <= alu_res.diff;
                    // first arrival after reset or a zero close: take a baseline
                    if (!alu_res.eq && (r_start == '0)) begin
                        r_start <= r_now;
                        r_valid <= '0;
                    end
                end
                ST_WIN2: begin
                    if (!alu_res.lt) begin
                        r_start <= r_now;
                        r_idx   <= '0;
                    end
                end
                ST_SW_CMP: begin
                    if (!stall) begin
                        if (!alu_res.lt) begin
                            if (!r_flags[r_idx]) begin
                                r_flags[r_idx] <= 1'b1;
                                // the held report is not the final one
                                if (r_pend_valid) begin
                                    r_out       <= r_pend;
                                    r_out_valid <= 1'b1;
                                end
                                r_pend       <= new_rep;
                                r_pend_valid <= 1'b1;
                            end
                        end else begin
                            r_flags[r_idx] <= 1'b0;
                        end
                        r_valid[r_idx] <= 1'b0;
                        r_idx          <= r_idx + 1'b1;
                    end
                end
                ST_END: begin
                    if (r_pend_valid && slot_free) begin
                        // held report with its last flag (lowest bit) set
                        r_out        <= {r_pend[$bits(t_report)-1:1], 1'b1};
                        r_out_valid  <= 1'b1;
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                    r_pend_valid <= r_pend_valid;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_report    = r_out;

    // a held report never survives the end of its sweep
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held report left after sweep");

    // the final report of a sweep goes out marked as last
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && r_pend_valid && slot_free) |=> (r_out_valid && r_out.last))
        else $error("final report not marked last");

    // taking a baseline clears every count
    a_baseline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIN1 && !alu_res.eq && r_start == '0) |=> (r_valid == '0))
        else $error("counts not cleared on baseline");

    // a stalled sweep step holds its vector
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW_CMP && stall) |=> (r_state == ST_SW_CMP && $stable(r_idx)))
        else $error("sweep moved on while stalled");

endmodule

@@ hw/rtl/interrupt_storm_detector_unit.sv @@
// Interrupt storm detector, top level: stream channels, register port, core.
// Input transfer on s_axis: one interrupt arrival (vector, millisecond time).
// Output transfer on m_axis: one report per vector newly found storming when
// a window closes; tlast marks the final report caused by one arrival.
// Registers over the APB-style port: 0x0 window_ms, 0x4 storm_threshold.
// Sequencing: s_axis_tready is high only while the sequencer is idle. An
// arrival that does not close a window runs a count read, count update, time
// compare and, if time moved on past a set baseline, a window compare, on the
// one shared subtract unit and the count memory with one write and one read
// port. An arrival that closes the window adds a sweep of a memory read and a
// threshold compare per vector and an end step that sends the final report.
// Reports pass through an output register and one held report, so the sweep
// only waits when both are full and the receiver holds m_axis_tready low.
// Reset (i_rst_n low at a clock edge) clears all counts at once through
// per-vector valid bits, clears the storm flags, drops any pending report,
// removes the time baseline and loads the register defaults of 100 ms and 2000.
module interrupt_storm_detector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb-style register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [isd_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,  // [5:0] vector, [37:6] now_ms
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // [5:0] storm_vector,
                                                       // [11:6] irq_line,
                                                       // [27:12] window_count
    output logic                        m_axis_tuser,  // [0] maskable
    output logic                        m_axis_tlast
);
    import isd_pkg::*;

    logic [CFG_W-1:0] r_window;
    logic [CFG_W-1:0] r_thresh;
    logic             cfg_write;
    t_cfg             cfg;
    t_report          report;

    // register writes in the access phase
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_thresh <= THRESH_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WINDOW) r_window <= pwdata[CFG_W-1:0];
            else r_thresh <= pwdata[CFG_W-1:0];
        end
    end

    // register read back
    assign prdata = (paddr[2] == REG_THRESH) ? 32'(r_thresh) : 32'(r_window);
    assign pready = 1'b1;

    assign cfg.window_ms       = r_window;
    assign cfg.storm_threshold = r_thresh;

    isd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_vector   (s_axis_tdata[5:0]),
        .i_now_ms   (s_axis_tdata[37:6]),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_report   (report)
    );

    // pack the report onto the output stream
    assign m_axis_tdata = {4'b0, report.window_count, report.irq_line, report.storm_vector};
    assign m_axis_tuser = report.maskable;
    assign m_axis_tlast = report.last;

endmodule
